// File: rtl/core/assert_macros.svh
// Assertion macros shared by the threshold event detector RTL.
// Depends on a clk and an arst_n signal in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define TED_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define TED_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ted_pkg.sv
// Types and constants of the threshold event detector.
// No dependencies; used by every module of the block.
package ted_pkg;

	localparam int SAMPLE_WIDTH    = 16;
	localparam int OUT_IDX_WIDTH   = 32;
	localparam int LEN_WIDTH       = 32;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int CFG_INDEX_WIDTH = 3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLARITY_MODE   = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD_LEVEL = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_EDGE_LEVEL      = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_LENGTH      = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_LENGTH      = 3'd4;

	// Polarity modes; the unused code acts as magnitude
	localparam logic [1:0] MODE_MAGNITUDE = 2'd0;
	localparam logic [1:0] MODE_GE        = 2'd1;
	localparam logic [1:0] MODE_LE        = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last_sample;
	} sample_t;

	typedef struct packed {
		logic [OUT_IDX_WIDTH-1:0] start_index;
		logic [OUT_IDX_WIDTH-1:0] stop_index;
	} result_t;

	// Per-sample level decisions
	typedef struct packed {
		logic pass_thr;
		logic miss_edge;
	} cls_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_ACTIVE = 3'b010,
		PH_TAIL   = 3'b100
	} phase_t;

endpackage

// File: rtl/core/ted_classify.sv
// Level compare of one sample against threshold and edge levels.
// Depends on ted_pkg.
module ted_classify (
	input  logic signed [ted_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic [1:0]                              polarity_mode,
	input  logic signed [ted_pkg::SAMPLE_WIDTH-1:0] threshold_level,
	input  logic signed [ted_pkg::SAMPLE_WIDTH-1:0] edge_level,
	output ted_pkg::cls_t                           cls
);
	localparam int SW = ted_pkg::SAMPLE_WIDTH;

	logic signed [SW:0] x_ext;
	logic signed [SW:0] mag;
	logic signed [SW:0] thr_ext;
	logic signed [SW:0] edg_ext;

	// one extra bit so the magnitude of the most negative sample fits
	assign x_ext   = $signed({sample[SW-1], sample});
	assign thr_ext = $signed({threshold_level[SW-1], threshold_level});
	assign edg_ext = $signed({edge_level[SW-1], edge_level});
	assign mag     = x_ext[SW] ? -x_ext : x_ext;

	always_comb begin
		case (polarity_mode)
			ted_pkg::MODE_GE: begin
				cls.pass_thr  = x_ext >= thr_ext;
				cls.miss_edge = !(x_ext >= edg_ext);
			end
			ted_pkg::MODE_LE: begin
				cls.pass_thr  = x_ext <= thr_ext;
				cls.miss_edge = !(x_ext <= edg_ext);
			end
			default: begin
				cls.pass_thr  = mag >= thr_ext;
				cls.miss_edge = !(mag >= edg_ext);
			end
		endcase
	end

endmodule

// File: rtl/core/ted_tracker.sv
// Event state tracking: sample index, event phase, start/stop and length check.
// Depends on ted_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ted_tracker #(
	parameter int INDEX_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            last,
	input  ted_pkg::cls_t                   cls,
	input  logic [ted_pkg::LEN_WIDTH-1:0]   min_length,
	input  logic [ted_pkg::LEN_WIDTH-1:0]   max_length,
	output logic                            emit,
	output ted_pkg::result_t                result
);
	localparam int LW = (INDEX_WIDTH > ted_pkg::LEN_WIDTH) ? INDEX_WIDTH : ted_pkg::LEN_WIDTH;
	localparam int OW = (INDEX_WIDTH > ted_pkg::OUT_IDX_WIDTH) ? INDEX_WIDTH
		: ted_pkg::OUT_IDX_WIDTH;

	logic [INDEX_WIDTH-1:0] cnt_q;
	logic [INDEX_WIDTH-1:0] lbe_q;
	logic                   seen_q;
	logic [INDEX_WIDTH-1:0] start_q;
	ted_pkg::phase_t        phase_q;
	logic                   real_q;

	ted_pkg::phase_t        ph_a, ph_b, ph_c;
	logic                   close_ev, begin_ev;
	logic [INDEX_WIDTH-1:0] stop_idx, len, start_new;
	logic [LW-1:0]          len_ext;
	logic                   len_ok;
	logic [OW-1:0]          start_out, stop_out;

	always_comb begin
		// active event drops below threshold -> tail
		ph_a = (phase_q == ted_pkg::PH_ACTIVE && !cls.pass_thr) ? ted_pkg::PH_TAIL : phase_q;
		close_ev = (ph_a == ted_pkg::PH_TAIL) && (cls.miss_edge || last);
		stop_idx = cls.miss_edge ? cnt_q - INDEX_WIDTH'(1) : cnt_q;
		len      = stop_idx - start_q;
		len_ext  = LW'(len);
		len_ok   = ((min_length == '0) || (len_ext >= LW'(min_length)))
			&& ((max_length == '0) || (len_ext <= LW'(max_length)));
		emit     = close_ev && real_q && len_ok;
		ph_b     = close_ev ? ted_pkg::PH_IDLE : ph_a;
		begin_ev = (ph_b == ted_pkg::PH_IDLE) && cls.pass_thr;
		if (cls.miss_edge)
			start_new = cnt_q;
		else if (seen_q)
			start_new = lbe_q + INDEX_WIDTH'(1);
		else
			start_new = '0;
		ph_c = begin_ev ? ted_pkg::PH_ACTIVE : ph_b;
	end

	assign start_out = OW'(start_q);
	assign stop_out  = OW'(stop_idx);
	assign result.start_index = start_out[ted_pkg::OUT_IDX_WIDTH-1:0];
	assign result.stop_index  = stop_out[ted_pkg::OUT_IDX_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			lbe_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
			phase_q <= ted_pkg::PH_ACTIVE;
			real_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				// end of series: back to the suppressed state
				cnt_q   <= '0;
				lbe_q   <= '0;
				seen_q  <= 1'b0;
				start_q <= '0;
				phase_q <= ted_pkg::PH_ACTIVE;
				real_q  <= 1'b0;
			end else begin
				cnt_q   <= cnt_q + INDEX_WIDTH'(1);
				phase_q <= ph_c;
				if (begin_ev) begin
					start_q <= start_new;
					real_q  <= 1'b1;
				end
				if (cls.miss_edge) begin
					lbe_q  <= cnt_q;
					seen_q <= 1'b1;
				end
			end
		end
	end

	`TED_ASSERT_IMP(a_emit_real, emit, real_q && (phase_q != ted_pkg::PH_IDLE),
		"event emitted while suppressed or idle")
	`TED_ASSERT_NXT(a_last_clears, step && last, (cnt_q == '0) && !real_q && !seen_q,
		"series end did not clear index state")
	`TED_ASSERT_NXT(a_idle_holds, !step, $stable(cnt_q) && $stable(phase_q),
		"tracker state moved without a sample")

endmodule

// File: rtl/core/threshold_event_detector.sv
// Threshold event detector, top level: input register, level compare, event
// tracker and result register. Depends on ted_pkg, ted_classify, ted_tracker.
//
// Takes one signed sample per transfer, numbers the samples from 0 and reports
// events: a run that starts when a sample passes threshold_level (magnitude,
// greater-or-equal or less-or-equal, by polarity_mode) and is bounded by
// edge_level on both sides. Start is the index just after the last sample that
// missed the edge level; stop is the last index before the next edge miss, or
// the final sample when last_sample ends the series during the tail. An event
// is reported when stop - start lies in [min_length, max_length], where 0 means
// no limit. Detection stays suppressed until the first sub-edge sample after
// reset or after a last_sample transfer, which also returns the index to 0.
// Throughput is one sample per clock while in_stall is low. A sample's result
// (if any) passes from the input register to the result register, from which it
// is offered on out_valid and taken while out_stall is low.
// A stall on the output only holds the input side once a sample waits in the
// input register behind a full result register.
// Configuration writes take effect on the next clock and are meant for idle
// periods only. Indices wrap at INDEX_WIDTH bits and are presented on 32 bits.
`include "assert_macros.svh"

module threshold_event_detector #(
	parameter int INDEX_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample input
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  ted_pkg::sample_t                      in_data,
	// event output
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output ted_pkg::result_t                      out_data,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [ted_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [ted_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
	localparam int SW = ted_pkg::SAMPLE_WIDTH;

	// configuration registers
	logic [1:0]                    mode_q;
	logic signed [SW-1:0]          thr_q;
	logic signed [SW-1:0]          edg_q;
	logic [ted_pkg::LEN_WIDTH-1:0] min_q;
	logic [ted_pkg::LEN_WIDTH-1:0] max_q;

	// input stage
	logic          valid_s1;
	logic          last_s1;
	ted_pkg::cls_t cls_in;
	ted_pkg::cls_t cls_s1;

	// result stage
	logic             out_valid_q;
	ted_pkg::result_t out_data_q;

	logic             step;
	logic             in_xfer;
	logic             emit;
	ted_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ted_pkg::MODE_GE;
			thr_q  <= '0;
			edg_q  <= '0;
			min_q  <= '0;
			max_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ted_pkg::REG_POLARITY_MODE:   mode_q <= cfg_data[1:0];
				ted_pkg::REG_THRESHOLD_LEVEL: thr_q  <= $signed(cfg_data[SW-1:0]);
				ted_pkg::REG_EDGE_LEVEL:      edg_q  <= $signed(cfg_data[SW-1:0]);
				ted_pkg::REG_MIN_LENGTH:      min_q  <= cfg_data[ted_pkg::LEN_WIDTH-1:0];
				ted_pkg::REG_MAX_LENGTH:      max_q  <= cfg_data[ted_pkg::LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// compare levels on the way into the input register
	ted_classify u_classify (
		.sample          (in_data.sample),
		.polarity_mode   (mode_q),
		.threshold_level (thr_q),
		.edge_level      (edg_q),
		.cls             (cls_in)
	);

	// the staged sample moves on when the result register is free or draining
	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cls_s1  <= cls_in;
			last_s1 <= in_data.last_sample;
		end
	end

	ted_tracker #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.last       (last_s1),
		.cls        (cls_s1),
		.min_length (min_q),
		.max_length (max_q),
		.emit       (emit),
		.result     (result)
	);

	// result register; a sample with no event just empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TED_ASSERT_IMP(a_stall_needs_item, in_stall, valid_s1,
		"input stalled with an empty input register")
	`TED_ASSERT_NXT(a_result_from_step, !valid_s1 && !out_valid_q, !out_valid_q,
		"result appeared without a staged sample")
	`TED_ASSERT_NXT(a_drain_empties, out_valid_q && !out_stall && !step, !out_valid_q,
		"taken result was not released")

endmodule
